### rtl/eac_pkg.sv
`default_nettype none
package eac_pkg;
    localparam int MaxStages = 32;
    localparam logic signed [33:0] Turn    = 34'sd23592960;
    localparam logic signed [33:0] Half    = 34'sd11796480;
    localparam logic signed [33:0] Quarter = 34'sd5898240;
    localparam logic signed [33:0] Threeq  = 34'sd17694720;
    localparam logic signed [33:0] HalfQ24 = 34'sd3019898880;

    localparam logic [0:0] CfgAxisFirst  = 1'b0;
    localparam logic [0:0] CfgAxisSecond = 1'b1;

    function automatic logic signed [33:0] atan_deg24(input int i);
        case (i)
            0: atan_deg24 = 34'sd754974720;
            1: atan_deg24 = 34'sd445687602;
            2: atan_deg24 = 34'sd235489088;
            3: atan_deg24 = 34'sd119537938;
            4: atan_deg24 = 34'sd60000934;
            5: atan_deg24 = 34'sd30029717;
            6: atan_deg24 = 34'sd15018523;
            7: atan_deg24 = 34'sd7509720;
            8: atan_deg24 = 34'sd3754917;
            9: atan_deg24 = 34'sd1877466;
            10: atan_deg24 = 34'sd938734;
            11: atan_deg24 = 34'sd469367;
            12: atan_deg24 = 34'sd234684;
            13: atan_deg24 = 34'sd117342;
            14: atan_deg24 = 34'sd58671;
            15: atan_deg24 = 34'sd29335;
            16: atan_deg24 = 34'sd14668;
            17: atan_deg24 = 34'sd7334;
            18: atan_deg24 = 34'sd3667;
            19: atan_deg24 = 34'sd1833;
            20: atan_deg24 = 34'sd917;
            21: atan_deg24 = 34'sd458;
            22: atan_deg24 = 34'sd229;
            23: atan_deg24 = 34'sd115;
            24: atan_deg24 = 34'sd57;
            25: atan_deg24 = 34'sd29;
            26: atan_deg24 = 34'sd14;
            27: atan_deg24 = 34'sd7;
            28: atan_deg24 = 34'sd4;
            29: atan_deg24 = 34'sd2;
            30: atan_deg24 = 34'sd1;
            default: atan_deg24 = 34'sd0;
        endcase
    endfunction

    // quotient by 45 through reciprocal multiplication, exact for 14-bit inputs
    function automatic logic [8:0] div45(input logic [13:0] n);
        logic [28:0] p;
        p = 29'(n) * 29'd23302;
        div45 = p[28:20];
    endfunction

    // per-angle side info carried down the chain
    typedef struct packed {
        logic                pass;
        logic                flip;
        logic signed [31:0]  orig;
        logic signed [47:0]  turn_add;
    } t_side;
endpackage
`default_nettype wire

### rtl/eac_rot_cell.sv
`default_nettype none
module eac_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire                     i_clk,
    input  wire                     i_vld,
    input  wire signed [33:0]       i_x,
    input  wire signed [33:0]       i_y,
    input  wire signed [33:0]       i_z,
    input  eac_pkg::t_side          i_side,
    output logic                    o_vld,
    output logic signed [33:0]      o_x,
    output logic signed [33:0]      o_y,
    output logic signed [33:0]      o_z,
    output eac_pkg::t_side          o_side
);
    import eac_pkg::*;
    logic signed [33:0] n_x, n_y, n_z;
    always_comb begin
        if (!i_z[33]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - atan_deg24(STAGE);
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + atan_deg24(STAGE);
        end
    end
    always_ff @(posedge i_clk) begin
        o_vld  <= i_vld;
        o_x    <= n_x;
        o_y    <= n_y;
        o_z    <= n_z;
        o_side <= i_side;
    end
endmodule
`default_nettype wire

### rtl/eac_vec_cell.sv
`default_nettype none
module eac_vec_cell #(
    parameter int STAGE = 0
) (
    input  wire                     i_clk,
    input  wire signed [49:0]       i_x,
    input  wire signed [49:0]       i_y,
    input  wire signed [35:0]       i_z,
    input  eac_pkg::t_side          i_side,
    output logic signed [49:0]      o_x,
    output logic signed [49:0]      o_y,
    output logic signed [35:0]      o_z,
    output eac_pkg::t_side          o_side
);
    import eac_pkg::*;
    logic signed [49:0] n_x, n_y;
    logic signed [35:0] n_z;
    always_comb begin
        if (!i_y[49]) begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + 36'(atan_deg24(STAGE));
        end else begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - 36'(atan_deg24(STAGE));
        end
    end
    always_ff @(posedge i_clk) begin
        o_x    <= n_x;
        o_y    <= n_y;
        o_z    <= n_z;
        o_side <= i_side;
    end
endmodule
`default_nettype wire

### rtl/eac_angle_path.sv
`default_nettype none
module eac_angle_path #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                i_clk,
    input  wire signed [31:0]  i_angle,
    input  wire                i_mode,
    input  wire signed [31:0]  i_axis_a,
    input  wire signed [31:0]  i_axis_b,
    output logic signed [31:0] o_angle
);
    import eac_pkg::*;
    localparam int N = CORDIC_STAGES;

    // stage 0: reduction and turn count
    logic signed [33:0] t, r, th;
    logic signed [12:0] h;
    logic [13:0] hu;
    logic [8:0] hq;
    logic [5:0] hrem;
    logic [31:0] tpos;
    logic [15:0] ip;
    logic signed [47:0] nturn;
    t_side n_side0;
    logic zero_ax;
    always_comb begin
        t = 34'(i_angle);
        // a turn is 45 * 2^19, so only the upper bits need a mod 45
        h = i_angle[31:19];
        hu = 14'(15'(h) + 15'sd4140);
        hq = div45(hu);
        hrem = 6'(hu - 14'(hq) * 14'd45);
        r = 34'({hrem, i_angle[18:0]});
        zero_ax = (i_axis_a == 32'sd0) || (i_axis_b == 32'sd0);
        if (!t[33]) tpos = 32'(t + Half);
        else tpos = 32'(Half - t);
        ip = 16'(tpos >> 16);
        nturn = $signed(48'(div45(14'(ip >> 3)))) * 48'sd23592960;
        if (t[33]) nturn = -nturn;
        n_side0.pass = zero_ax || r == 34'sd0 || r == Half || r == Quarter || r == Threeq;
        n_side0.flip = 1'b0;
        n_side0.orig = i_angle;
        n_side0.turn_add = nturn;
        if (r <= Quarter) th = r;
        else if (r < Threeq) begin th = r - Half; n_side0.flip = 1'b1; end
        else th = r - Turn;
    end
    logic signed [33:0] r_th;
    t_side r_side0;
    logic r_mode0;
    logic signed [31:0] r_a0, r_b0;
    always_ff @(posedge i_clk) begin
        r_th <= th;
        r_side0 <= n_side0;
        r_mode0 <= i_mode;
        r_a0 <= i_axis_a;
        r_b0 <= i_axis_b;
    end

    // rotation chain
    logic signed [33:0] rx [0:N];
    logic signed [33:0] ry [0:N];
    logic signed [33:0] rz [0:N];
    t_side rs [0:N];
    logic rm [0:N];
    logic rv [0:N];
    assign rx[0] = 34'sd1073741824;
    assign ry[0] = '0;
    assign rz[0] = r_th <<< 8;
    assign rs[0] = r_side0;
    assign rv[0] = r_mode0;
    assign rm[0] = r_mode0;
    for (genvar g = 0; g < N; g++) begin : g_rot
        eac_rot_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_vld(rv[g]), .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]),
            .i_side(rs[g]), .o_vld(rv[g+1]), .o_x(rx[g+1]), .o_y(ry[g+1]),
            .o_z(rz[g+1]), .o_side(rs[g+1]));
        assign rm[g+1] = rv[g+1];
    end

    // axes must be kept static during operation (not enforced here) so the stage-0 copies serve all stages
    logic signed [33:0] fx, fy;
    assign fx = rs[N].flip ? -rx[N] : rx[N];
    assign fy = rs[N].flip ? -ry[N] : ry[N];

    logic signed [65:0] p_y, p_x;
    always_comb begin
        if (!rm[N]) begin
            p_y = 66'(r_b0) * 66'(fy);
            p_x = 66'(r_a0) * 66'(fx);
        end else begin
            p_y = 66'(r_a0) * 66'(fy);
            p_x = 66'(r_b0) * 66'(fx);
        end
    end
    logic signed [65:0] r_py, r_px;
    logic r_neg;
    t_side r_side1;
    always_ff @(posedge i_clk) begin
        r_py <= p_y;
        r_px <= p_x;
        r_neg <= rm[N] && (r_a0[31] != r_b0[31]);
        r_side1 <= rs[N];
    end

    logic signed [49:0] vy0, vx0, vy1, vx1;
    logic signed [35:0] z0;
    always_comb begin
        vy0 = 50'(r_py >>> 16);
        vx0 = 50'(r_px >>> 16);
        if (r_neg) begin vy0 = -vy0; vx0 = -vx0; end
        z0 = '0;
        vx1 = vx0;
        vy1 = vy0;
        if (vx0[49]) begin
            z0 = vy0[49] ? -36'(HalfQ24) : 36'(HalfQ24);
            vx1 = -vx0;
            vy1 = -vy0;
        end
    end
    logic signed [49:0] vx [0:N];
    logic signed [49:0] vy [0:N];
    logic signed [35:0] vz [0:N];
    t_side vs [0:N];
    always_ff @(posedge i_clk) begin
        vx[0] <= vx1;
        vy[0] <= vy1;
        vz[0] <= z0;
        vs[0] <= r_side1;
    end
    for (genvar g = 0; g < N; g++) begin : g_vec
        eac_vec_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]), .i_side(vs[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]), .o_side(vs[g+1]));
    end

    logic signed [47:0] q, sum;
    always_comb begin
        q = 48'((vz[N] + 36'sd128) >>> 8);
        sum = q + vs[N].turn_add;
        if (vs[N].pass) o_angle = vs[N].orig;
        else if (sum > 48'sd2147483647) o_angle = 32'sh7fffffff;
        else if (sum < -48'sd2147483648) o_angle = 32'sh80000000;
        else o_angle = 32'(sum);
    end
endmodule
`default_nettype wire

### rtl/ellipse_angle_converter.sv
// throughput: one item per cycle, set by the two unrolled CORDIC cell chains
// busy is always low; o_done pulses once per item in order
// reset (synchronous, active low) clears the valid chain and sets both axes to 1.0
// results are not held: the receiver cannot stall
`default_nettype none
module ellipse_angle_converter #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire                i_operation,
    input  wire signed [31:0]  i_start_angle,
    input  wire signed [31:0]  i_end_angle,
    output logic               o_done,
    output logic signed [31:0] o_start_converted,
    output logic signed [31:0] o_end_converted,
    output logic               o_closed,
    output logic               o_status,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [0:0]          i_cfg_index,
    input  wire [31:0]         i_cfg_data
);
    import eac_pkg::*;
    localparam int Lat = 2 * CORDIC_STAGES + 3;

    logic signed [31:0] r_a, r_b;
    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 32'sd65536;
            r_b <= 32'sd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgAxisFirst: r_a <= i_cfg_data;
                CfgAxisSecond: r_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    eac_angle_path #(.CORDIC_STAGES(CORDIC_STAGES)) u_start (
        .i_clk(i_clk), .i_angle(i_start_angle), .i_mode(i_operation),
        .i_axis_a(r_a), .i_axis_b(r_b), .o_angle(o_start_converted));
    eac_angle_path #(.CORDIC_STAGES(CORDIC_STAGES)) u_end (
        .i_clk(i_clk), .i_angle(i_end_angle), .i_mode(i_operation),
        .i_axis_a(r_a), .i_axis_b(r_b), .o_angle(o_end_converted));

    logic signed [32:0] d, da;
    logic [13:0] dh;
    logic [8:0] dq;
    logic [5:0] drem;
    logic n_closed, n_status;
    always_comb begin
        d = 33'(i_end_angle) - 33'(i_start_angle);
        da = d[32] ? -d : d;
        // a turn is 45 * 2^19
        dh = da[32:19];
        dq = div45(dh);
        drem = 6'(dh - 14'(dq) * 14'd45);
        n_closed = (da[18:0] == 19'd0) && (drem == 6'd0);
        n_status = i_operation && (r_a == 32'sd0 || r_b == 32'sd0);
    end

    logic [Lat-1:0] r_vld, r_cl, r_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[Lat-2:0], start};
        r_cl <= {r_cl[Lat-2:0], n_closed};
        r_st <= {r_st[Lat-2:0], n_status};
    end
    assign o_done = r_vld[Lat-1];
    assign o_closed = r_cl[Lat-1];
    assign o_status = r_st[Lat-1];

    a_busy_low: assert property (@(posedge i_clk) !busy) else $error("busy");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(Lat) o_done) else $error("latency");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CfgAxisFirst) |=> r_a == $past(i_cfg_data))
        else $error("cfg");
endmodule
`default_nettype wire
